FILE: hdl/lgba_pkg.sv
// ----------------------------------------------------------------------------
// lgba_pkg
// Types and constants shared by the longitude/latitude grid bin averager.
// ----------------------------------------------------------------------------
package lgba_pkg;

   localparam int LON_FULL   = 92160;
   localparam int LAT_FULL   = 46080;
   localparam int LAT_OFFSET = 23040;

   // 2*LON_FULL = 45 << 12 and 2*LAT_FULL = 45 << 11; divide by 45 through
   // a multiply by 2^20/45 rounded up, exact for numerators below 2^16
   localparam int LON_SHIFT        = 12;
   localparam int LAT_SHIFT        = 11;
   localparam int GRID_RECIP       = 23302;
   localparam int GRID_RECIP_SHIFT = 20;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   localparam int DIV_DW = 40;
   localparam int DIV_VW = 18;

   localparam logic [37:0]        WINDOW_START_RST  = 38'd0;
   localparam logic [23:0]        WINDOW_LENGTH_RST = 24'd364708;
   localparam logic [15:0]        CONTOUR_STEP_RST  = 16'd5120;
   localparam logic signed [23:0] MIN_RST           = 24'sh7FFFFF;
   localparam logic signed [23:0] MAX_RST           = 24'sh000000;

   typedef enum logic [1:0] {
      REQ_ADD,
      REQ_READ_BIN,
      REQ_READ_RANGE,
      REQ_CLEAR
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_WINDOW,
      STATUS_GRID,
      STATUS_SATURATED
   } status_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_START,
      CSR_WINDOW_LENGTH,
      CSR_CONTOUR_STEP
   } csr_index_type;

   typedef struct packed {
      logic signed [39:0] sum;
      logic [15:0]        count;
   } cell_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_XCALC,
      ST_YCALC,
      ST_ADDR,
      ST_FETCH,
      ST_UPDATE,
      ST_MEANGO,
      ST_MEANWAIT,
      ST_LOGO,
      ST_LOWAIT,
      ST_LOMUL,
      ST_HIGO,
      ST_HIWAIT,
      ST_HIMUL
   } state_type;

endpackage

FILE: hdl/lgba_div.sv
// ----------------------------------------------------------------------------
// lgba_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lgba_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lgba_pkg::DIV_DW-1:0]   dividend,
   input  logic [lgba_pkg::DIV_VW-1:0]   divisor,
   output logic                          done,
   output logic [lgba_pkg::DIV_DW-1:0]   quotient,
   output logic [lgba_pkg::DIV_VW-1:0]   remainder
);

   localparam int DW = lgba_pkg::DIV_DW;
   localparam int VW = lgba_pkg::DIV_VW;
   localparam int CW = $clog2(DW);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] div_ff, div_in;
   logic [VW:0]   trial;
   logic [VW:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      diff    = trial - {1'b0, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = trial[VW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/lgba_grid.sv
// ----------------------------------------------------------------------------
// lgba_grid
// Grid memory of bin sums and hit counts, one write and one registered read.
// ----------------------------------------------------------------------------
module lgba_grid #(
   parameter int CELLS = 2701,
   parameter int AW    = 12
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  lgba_pkg::cell_type wr_data,
   input  logic [AW-1:0]      rd_addr,
   output lgba_pkg::cell_type rd_data
);

   lgba_pkg::cell_type grid_ff [CELLS];
   lgba_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= grid_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/lonlat_grid_bin_averager.sv
// ----------------------------------------------------------------------------
// lonlat_grid_bin_averager
// Bins timed lon/lat samples into a grid of sums and counts, reads bin means,
// the rounded value range, and clears the grid.
//
//   channel   handshake          payload
//   req_      start / busy       type, time, lon, lat, value, bin x/y
//   rsp_      rsp_valid strobe   status, mean, hits, range low/high
//   csr_      csr_we             index, write data
//
// One request at a time; busy drops in the cycle of its response strobe.
// An add uses one reciprocal multiply per bin index, a read of a non-empty bin
// one pass of the shared divider and a range read two; a clear writes every
// cell, and a rejected add or read finishes early.
// After reset a clearing pass over all LON_BINS*LAT_BINS cells runs with busy high.
// Responses are never stalled.
// ----------------------------------------------------------------------------
module lonlat_grid_bin_averager #(
   parameter int LON_BINS = 73,
   parameter int LAT_BINS = 37
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [37:0]        req_sample_time,
   input  logic [16:0]        req_sample_lon,
   input  logic signed [15:0] req_sample_lat,
   input  logic signed [23:0] req_sample_value,
   input  logic [6:0]         req_bin_x,
   input  logic [5:0]         req_bin_y,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [23:0] rsp_bin_mean,
   output logic [15:0]        rsp_bin_hits,
   output logic signed [24:0] rsp_range_low,
   output logic signed [24:0] rsp_range_high,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [37:0]        csr_wdata
);

   localparam int CELLS = LON_BINS * LAT_BINS;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(LON_BINS);
   localparam int YW    = $clog2(LAT_BINS);
   localparam int DW    = lgba_pkg::DIV_DW;
   localparam int VW    = lgba_pkg::DIV_VW;

   lgba_pkg::state_type    state_ff, state_in;
   lgba_pkg::req_code_type op_ff, op_in;

   logic [37:0]        cfg_start_ff, cfg_start_in;
   logic [23:0]        cfg_len_ff, cfg_len_in;
   logic [15:0]        cfg_step_ff, cfg_step_in;

   logic [37:0]        time_ff, time_in;
   logic [16:0]        lon_ff, lon_in;
   logic signed [15:0] lat_ff, lat_in;
   logic signed [23:0] val_ff, val_in;
   logic [6:0]         bx_ff, bx_in;
   logic [5:0]         by_ff, by_in;

   logic [24:0]        nx_ff, nx_in;
   logic signed [25:0] ny_ff, ny_in;
   logic [XW-1:0]      ix_ff, ix_in;
   logic [YW-1:0]      iy_ff, iy_in;
   logic               bad_ff, bad_in;
   logic [AW-1:0]      addr_ff, addr_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               clr_req_ff, clr_req_in;
   logic               neg_ff, neg_in;
   logic [15:0]        hits_ff, hits_in;
   logic signed [23:0] min_ff, min_in;
   logic signed [23:0] max_ff, max_in;
   logic signed [24:0] lo_ff, lo_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic signed [23:0] rsp_mean_ff, rsp_mean_in;
   logic [15:0]        rsp_hits_ff, rsp_hits_in;
   logic signed [24:0] rsp_low_ff, rsp_low_in;
   logic signed [24:0] rsp_high_ff, rsp_high_in;

   logic               div_start;
   logic [DW-1:0]      div_dividend;
   logic [VW-1:0]      div_divisor;
   logic               div_done;
   logic [DW-1:0]      div_quo;
   logic [VW-1:0]      div_rem;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   lgba_pkg::cell_type wr_data;
   lgba_pkg::cell_type rd_cell;

   logic [38:0]        win_end;
   logic               outside;
   logic [25:0]        ny_mag;
   logic [27:0]        x_num;
   logic [27:0]        y_num;
   logic [14:0]        rcp_in;
   logic [29:0]        rcp_prod;
   logic [9:0]         rcp_q;
   logic [39:0]        sum_mag;
   logic [23:0]        v_mag;
   logic               v_neg;
   logic [15:0]        step_eff;
   logic [24:0]        q_adj;
   logic [40:0]        prod;
   logic [39:0]        mean_abs;
   logic signed [39:0] mean_s;
   logic signed [40:0] prod_s;
   logic               y_bad;

   lgba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   lgba_grid #(
      .CELLS (CELLS),
      .AW    (AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_cell)
   );

   always_comb begin
      win_end  = {1'b0, cfg_start_ff} + 39'(cfg_len_ff);
      outside  = (time_ff < cfg_start_ff) || ({1'b0, time_ff} > win_end);
      ny_mag   = ny_ff[25] ? 26'(-ny_ff) : 26'(ny_ff);
      x_num    = 28'({nx_ff, 1'b0}) + 28'(lgba_pkg::LON_FULL);
      y_num    = 28'({ny_mag, 1'b0}) + 28'(lgba_pkg::LAT_FULL);
      rcp_in   = (state_ff == lgba_pkg::ST_YCALC) ? y_num[lgba_pkg::LAT_SHIFT +: 15]
                                                  : x_num[lgba_pkg::LON_SHIFT +: 15];
      rcp_prod = 30'(rcp_in) * 30'(lgba_pkg::GRID_RECIP);
      rcp_q    = rcp_prod[lgba_pkg::GRID_RECIP_SHIFT +: 10];
      sum_mag  = rd_cell.sum[39] ? 40'(-rd_cell.sum) : 40'(rd_cell.sum);
      v_neg    = (state_ff == lgba_pkg::ST_LOGO || state_ff == lgba_pkg::ST_LOWAIT ||
                  state_ff == lgba_pkg::ST_LOMUL) ? min_ff[23] : max_ff[23];
      v_mag    = (state_ff == lgba_pkg::ST_LOGO) ? (min_ff[23] ? 24'(-min_ff) : 24'(min_ff))
                                                 : (max_ff[23] ? 24'(-max_ff) : 24'(max_ff));
      step_eff = (cfg_step_ff == 16'd0) ? 16'd1 : cfg_step_ff;
      y_bad    = (ny_ff[25] && rcp_q != '0) || (rcp_q >= 10'(LAT_BINS));
      mean_abs = neg_ff ? 40'(-div_quo) : div_quo;
      mean_s   = signed'(mean_abs);
      if (state_ff == lgba_pkg::ST_LOMUL) begin
         q_adj = div_quo[24:0] + 25'((min_ff[23] && div_rem != '0) ? 1 : 0);
      end else begin
         q_adj = div_quo[24:0] + 25'((!max_ff[23] && div_rem != '0) ? 1 : 0);
      end
      prod     = 41'(q_adj) * 41'(step_eff);
      prod_s   = v_neg ? signed'(41'(-prod)) : signed'(prod);

      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         lgba_pkg::ST_MEANGO: begin
            div_start    = 1'b1;
            div_dividend = sum_mag;
            div_divisor  = VW'(hits_ff);
         end
         lgba_pkg::ST_LOGO, lgba_pkg::ST_HIGO: begin
            div_start    = 1'b1;
            div_dividend = DW'(v_mag);
            div_divisor  = VW'(step_eff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      time_in       = time_ff;
      lon_in        = lon_ff;
      lat_in        = lat_ff;
      val_in        = val_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      nx_in         = nx_ff;
      ny_in         = ny_ff;
      ix_in         = ix_ff;
      iy_in         = iy_ff;
      bad_in        = bad_ff;
      addr_in       = addr_ff;
      clr_in        = clr_ff;
      clr_req_in    = clr_req_ff;
      neg_in        = neg_ff;
      hits_in       = hits_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_hits_in   = rsp_hits_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = '0;

      cfg_start_in = cfg_start_ff;
      cfg_len_in   = cfg_len_ff;
      cfg_step_in  = cfg_step_ff;
      if (csr_we) begin
         unique case (lgba_pkg::csr_index_type'(csr_index))
            lgba_pkg::CSR_WINDOW_START:  cfg_start_in = csr_wdata;
            lgba_pkg::CSR_WINDOW_LENGTH: cfg_len_in   = csr_wdata[23:0];
            lgba_pkg::CSR_CONTOUR_STEP:  cfg_step_in  = csr_wdata[15:0];
            default: begin
               cfg_start_in = cfg_start_ff;
            end
         endcase
      end

      unique case (state_ff)
         lgba_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = lgba_pkg::ST_IDLE;
               if (clr_req_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = lgba_pkg::STATUS_OK;
                  rsp_mean_in   = '0;
                  rsp_hits_in   = '0;
                  rsp_low_in    = '0;
                  rsp_high_in   = '0;
               end
            end
         end
         lgba_pkg::ST_IDLE: begin
            if (start) begin
               op_in    = lgba_pkg::req_code_type'(req_type);
               time_in  = req_sample_time;
               lon_in   = req_sample_lon;
               lat_in   = req_sample_lat;
               val_in   = req_sample_value;
               bx_in    = req_bin_x;
               by_in    = req_bin_y;
               state_in = lgba_pkg::ST_DISPATCH;
            end
         end
         lgba_pkg::ST_DISPATCH: begin
            rsp_mean_in = '0;
            rsp_hits_in = '0;
            rsp_low_in  = '0;
            rsp_high_in = '0;
            nx_in = 25'(lon_ff) * 25'(LON_BINS - 1);
            ny_in = (26'(lat_ff) + 26'(lgba_pkg::LAT_OFFSET)) * 26'(LAT_BINS - 1);
            unique case (op_ff)
               lgba_pkg::REQ_ADD: begin
                  if (outside) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = lgba_pkg::STATUS_WINDOW;
                     state_in      = lgba_pkg::ST_IDLE;
                  end else begin
                     state_in = lgba_pkg::ST_XCALC;
                  end
               end
               lgba_pkg::REQ_READ_BIN: begin
                  if (32'(bx_ff) >= LON_BINS || 32'(by_ff) >= LAT_BINS) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = lgba_pkg::STATUS_GRID;
                     state_in      = lgba_pkg::ST_IDLE;
                  end else begin
                     state_in = lgba_pkg::ST_ADDR;
                  end
               end
               lgba_pkg::REQ_READ_RANGE: begin
                  state_in = lgba_pkg::ST_LOGO;
               end
               lgba_pkg::REQ_CLEAR: begin
                  clr_in     = '0;
                  clr_req_in = 1'b1;
                  state_in   = lgba_pkg::ST_CLEAR;
               end
            endcase
         end
         lgba_pkg::ST_XCALC: begin
            bad_in   = rcp_q >= 10'(LON_BINS);
            ix_in    = rcp_q[XW-1:0];
            state_in = lgba_pkg::ST_YCALC;
         end
         lgba_pkg::ST_YCALC: begin
            iy_in = rcp_q[YW-1:0];
            if (bad_ff || y_bad) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lgba_pkg::STATUS_GRID;
               state_in      = lgba_pkg::ST_IDLE;
            end else begin
               state_in = lgba_pkg::ST_ADDR;
            end
         end
         lgba_pkg::ST_ADDR: begin
            if (op_ff == lgba_pkg::REQ_ADD) begin
               addr_in = AW'(32'(ix_ff) * LAT_BINS + 32'(iy_ff));
            end else begin
               addr_in = AW'(32'(bx_ff) * LAT_BINS + 32'(by_ff));
            end
            state_in = lgba_pkg::ST_FETCH;
         end
         lgba_pkg::ST_FETCH: begin
            state_in = lgba_pkg::ST_UPDATE;
         end
         lgba_pkg::ST_UPDATE: begin
            state_in = lgba_pkg::ST_IDLE;
            hits_in  = rd_cell.count;
            neg_in   = rd_cell.sum[39];
            if (op_ff == lgba_pkg::REQ_ADD) begin
               rsp_valid_in = 1'b1;
               if (rd_cell.count == lgba_pkg::COUNT_MAX) begin
                  rsp_status_in = lgba_pkg::STATUS_SATURATED;
               end else begin
                  rsp_status_in = lgba_pkg::STATUS_OK;
                  wr_en         = 1'b1;
                  wr_data.sum   = rd_cell.sum + 40'(val_ff);
                  wr_data.count = rd_cell.count + 16'd1;
                  if (val_ff < min_ff) begin
                     min_in = val_ff;
                  end
                  if (val_ff > max_ff) begin
                     max_in = val_ff;
                  end
               end
            end else if (rd_cell.count == 16'd0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lgba_pkg::STATUS_OK;
            end else begin
               state_in = lgba_pkg::ST_MEANGO;
            end
         end
         lgba_pkg::ST_MEANGO: begin
            state_in = lgba_pkg::ST_MEANWAIT;
         end
         lgba_pkg::ST_MEANWAIT: begin
            if (div_done) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = lgba_pkg::STATUS_OK;
               rsp_mean_in   = mean_s[23:0];
               rsp_hits_in   = hits_ff;
               state_in      = lgba_pkg::ST_IDLE;
            end
         end
         lgba_pkg::ST_LOGO: begin
            state_in = lgba_pkg::ST_LOWAIT;
         end
         lgba_pkg::ST_LOWAIT: begin
            if (div_done) begin
               state_in = lgba_pkg::ST_LOMUL;
            end
         end
         lgba_pkg::ST_LOMUL: begin
            lo_in    = prod_s[24:0];
            state_in = lgba_pkg::ST_HIGO;
         end
         lgba_pkg::ST_HIGO: begin
            state_in = lgba_pkg::ST_HIWAIT;
         end
         lgba_pkg::ST_HIWAIT: begin
            if (div_done) begin
               state_in = lgba_pkg::ST_HIMUL;
            end
         end
         lgba_pkg::ST_HIMUL: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = lgba_pkg::STATUS_OK;
            rsp_low_in    = lo_ff;
            rsp_high_in   = prod_s[24:0];
            state_in      = lgba_pkg::ST_IDLE;
         end
         default: begin
            state_in = lgba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lgba_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_req_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= lgba_pkg::MIN_RST;
         max_ff       <= lgba_pkg::MAX_RST;
         cfg_start_ff <= lgba_pkg::WINDOW_START_RST;
         cfg_len_ff   <= lgba_pkg::WINDOW_LENGTH_RST;
         cfg_step_ff  <= lgba_pkg::CONTOUR_STEP_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_req_ff   <= clr_req_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         cfg_start_ff <= cfg_start_in;
         cfg_len_ff   <= cfg_len_in;
         cfg_step_ff  <= cfg_step_in;
      end
      op_ff         <= op_in;
      time_ff       <= time_in;
      lon_ff        <= lon_in;
      lat_ff        <= lat_in;
      val_ff        <= val_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      nx_ff         <= nx_in;
      ny_ff         <= ny_in;
      ix_ff         <= ix_in;
      iy_ff         <= iy_in;
      bad_ff        <= bad_in;
      addr_ff       <= addr_in;
      neg_ff        <= neg_in;
      hits_ff       <= hits_in;
      lo_ff         <= lo_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_hits_ff   <= rsp_hits_in;
      rsp_low_ff    <= rsp_low_in;
      rsp_high_ff   <= rsp_high_in;
   end

   assign busy           = (state_ff != lgba_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_bin_mean   = rsp_mean_ff;
   assign rsp_bin_hits   = rsp_hits_ff;
   assign rsp_range_low  = rsp_low_ff;
   assign rsp_range_high = rsp_high_ff;

endmodule

FILE: tb/tb_lonlat_grid_bin_averager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lonlat_grid_bin_averager
// Drives add, bin-read, range-read and clear requests with random gaps and
// checks every response against a behavioral grid model held in the bench.
// ----------------------------------------------------------------------------
module tb_lonlat_grid_bin_averager;

   localparam int LON_BINS  = 73;
   localparam int LAT_BINS  = 37;
   localparam int CELLS     = LON_BINS * LAT_BINS;
   localparam int WDOG_MAX  = 20000;

   typedef struct packed {
      logic [1:0]         kind;
      logic [37:0]        stime;
      logic [16:0]        lon;
      logic signed [15:0] lat;
      logic signed [23:0] value;
      logic [6:0]         bx;
      logic [5:0]         by;
   } grid_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [23:0] mean;
      logic [15:0]        hits;
      logic signed [24:0] lo;
      logic signed [24:0] hi;
   } grid_rsp_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   logic [1:0] req_type = 0;
   logic [37:0] req_sample_time = 0;
   logic [16:0] req_sample_lon = 0;
   logic signed [15:0] req_sample_lat = 0;
   logic signed [23:0] req_sample_value = 0;
   logic [6:0] req_bin_x = 0;
   logic [5:0] req_bin_y = 0;
   logic [1:0] rsp_status;
   logic signed [23:0] rsp_bin_mean;
   logic [15:0] rsp_bin_hits;
   logic signed [24:0] rsp_range_low, rsp_range_high;
   logic csr_we = 0;
   logic [1:0] csr_index = 0;
   logic [37:0] csr_wdata = 0;

   lonlat_grid_bin_averager #(.LON_BINS(LON_BINS), .LAT_BINS(LAT_BINS)) uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // bench copy of grid state and registers
   longint grid_sum[CELLS];
   int     grid_cnt[CELLS];
   longint run_min, run_max;
   longint win_start, win_len, step_reg;

   grid_req_type pending_reqs[$];
   grid_rsp_type expected_rsps[$];
   int  errors = 0;
   int  wdog = 0;
   bit  hold_tx = 1;
   int  burst_left = 0, gap_left = 0;

   function automatic longint rdiv(longint n, longint d);
      if (n >= 0) return (2 * n + d) / (2 * d);
      return -((-2 * n + d) / (2 * d));
   endfunction

   function automatic longint floor_step(longint v, longint s);
      longint q;
      q = v / s;
      if (q * s > v) q -= 1;
      return q * s;
   endfunction

   function automatic longint ceil_step(longint v, longint s);
      longint q;
      q = v / s;
      if (q * s < v) q += 1;
      return q * s;
   endfunction

   function automatic grid_rsp_type predict_grid(grid_req_type r);
      grid_rsp_type o;
      longint ix, iy, val, s;
      int c;
      o = '0;
      case (r.kind)
         lgba_pkg::REQ_ADD: begin
            val = r.value;
            if (r.stime < win_start || r.stime > win_start + win_len) begin
               o.status = lgba_pkg::STATUS_WINDOW;
            end else begin
               ix = rdiv(longint'(r.lon) * (LON_BINS - 1), lgba_pkg::LON_FULL);
               iy = rdiv((longint'(r.lat) + lgba_pkg::LAT_OFFSET) * (LAT_BINS - 1),
                         lgba_pkg::LAT_FULL);
               if (ix < 0 || ix >= LON_BINS || iy < 0 || iy >= LAT_BINS) begin
                  o.status = lgba_pkg::STATUS_GRID;
               end else begin
                  c = int'(ix * LAT_BINS + iy);
                  if (grid_cnt[c] >= 65535) begin
                     o.status = lgba_pkg::STATUS_SATURATED;
                  end else begin
                     grid_sum[c] += val;
                     grid_cnt[c] += 1;
                     if (val < run_min) run_min = val;
                     if (val > run_max) run_max = val;
                  end
               end
            end
         end
         lgba_pkg::REQ_READ_BIN: begin
            if (r.bx >= LON_BINS || r.by >= LAT_BINS) begin
               o.status = lgba_pkg::STATUS_GRID;
            end else begin
               c = r.bx * LAT_BINS + r.by;
               o.hits = 16'(grid_cnt[c]);
               if (grid_cnt[c] > 0) o.mean = 24'(grid_sum[c] / grid_cnt[c]);
            end
         end
         lgba_pkg::REQ_READ_RANGE: begin
            s = (step_reg == 0) ? 1 : step_reg;
            o.lo = 25'(floor_step(run_min, s));
            o.hi = 25'(ceil_step(run_max, s));
         end
         default: begin
            foreach (grid_sum[i]) begin
               grid_sum[i] = 0;
               grid_cnt[i] = 0;
            end
         end
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && !busy) begin
         // transfer taken; load next or drop start
         if (!hold_tx && burst_left > 0 && pending_reqs.size() > 0) begin
            req_type         <= pending_reqs[0].kind;
            req_sample_time  <= pending_reqs[0].stime;
            req_sample_lon   <= pending_reqs[0].lon;
            req_sample_lat   <= pending_reqs[0].lat;
            req_sample_value <= pending_reqs[0].value;
            req_bin_x        <= pending_reqs[0].bx;
            req_bin_y        <= pending_reqs[0].by;
            expected_rsps.push_back(predict_grid(pending_reqs.pop_front()));
            burst_left <= burst_left - 1;
         end else begin
            start <= 0;
            if (burst_left <= 1) gap_left <= $urandom_range(0, 8) == 0 ? 0 : $urandom_range(0, 200);
         end
      end else if (!start) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (!hold_tx && pending_reqs.size() > 0) begin
            req_type         <= pending_reqs[0].kind;
            req_sample_time  <= pending_reqs[0].stime;
            req_sample_lon   <= pending_reqs[0].lon;
            req_sample_lat   <= pending_reqs[0].lat;
            req_sample_value <= pending_reqs[0].value;
            req_bin_x        <= pending_reqs[0].bx;
            req_bin_y        <= pending_reqs[0].by;
            expected_rsps.push_back(predict_grid(pending_reqs.pop_front()));
            start <= 1;
            burst_left <= $urandom_range(1, 12);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected");
            errors++;
         end else begin
            grid_rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
            if (rsp_bin_mean !== e.mean) begin
               $error("bin_mean exp %0d got %0d", e.mean, rsp_bin_mean); errors++;
            end
            if (rsp_bin_hits !== e.hits) begin
               $error("bin_hits exp %0d got %0d", e.hits, rsp_bin_hits); errors++;
            end
            if (rsp_range_low !== e.lo) begin
               $error("range_low exp %0d got %0d", e.lo, rsp_range_low); errors++;
            end
            if (rsp_range_high !== e.hi) begin
               $error("range_high exp %0d got %0d", e.hi, rsp_range_high); errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) wdog <= 0;
      else wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic csr_write(lgba_pkg::csr_index_type idx, longint val);
      @(posedge clock);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= val[37:0];
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         lgba_pkg::CSR_WINDOW_START:  win_start = val & 38'h3FFFFFFFFF;
         lgba_pkg::CSR_WINDOW_LENGTH: win_len   = val & 24'hFFFFFF;
         default:                     step_reg  = val & 16'hFFFF;
      endcase
   endtask

   task automatic drain_grid();
      hold_tx = 0;
      wait (pending_reqs.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      hold_tx = 1;
      repeat (LON_BINS * LAT_BINS + 200) @(posedge clock);
   endtask

   function automatic grid_req_type make_add(longint t, int lon, int lat, int val);
      grid_req_type r;
      r = '0;
      r.kind = lgba_pkg::REQ_ADD; r.stime = 38'(t); r.lon = 17'(lon);
      r.lat = 16'(lat); r.value = 24'(val);
      r.bx = 7'($urandom); r.by = 6'($urandom);
      return r;
   endfunction

   function automatic grid_req_type make_op(lgba_pkg::req_code_type k, int bx, int by);
      grid_req_type r;
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      r = raw[$bits(grid_req_type)-1:0];
      r.kind = k; r.bx = 7'(bx); r.by = 6'(by);
      return r;
   endfunction

   // window-aware random request; most adds land inside the window
   function automatic grid_req_type rand_req(int hot_x, int hot_y);
      grid_req_type r;
      int p;
      longint t;
      p = $urandom_range(0, 99);
      if (p < 62) begin
         t = win_start + (longint'($urandom) % (win_len + 1));
         if ($urandom_range(0, 9) == 0) t = {$urandom, $urandom};
         r = make_add(t, $urandom_range(0, 9) == 0 ? int'($urandom) :
                         int'($urandom_range(0, lgba_pkg::LON_FULL)),
                      $urandom_range(0, 9) == 0 ? int'($urandom) :
                      int'($urandom_range(0, lgba_pkg::LAT_FULL)) - lgba_pkg::LAT_OFFSET,
                      int'($urandom));
         if ($urandom_range(0, 3) == 0) begin
            r.lon = 17'(hot_x * lgba_pkg::LON_FULL / (LON_BINS - 1));
            r.lat = 16'(hot_y * lgba_pkg::LAT_FULL / (LAT_BINS - 1) - lgba_pkg::LAT_OFFSET);
         end
         if ($urandom_range(0, 1)) r.value = $signed(r.value) >>> $urandom_range(0, 20);
      end else if (p < 85) begin
         r = make_op(lgba_pkg::REQ_READ_BIN, $urandom_range(0, 7) == 0 ? int'($urandom) : hot_x,
                     $urandom_range(0, 7) == 0 ? int'($urandom) : hot_y);
         if ($urandom_range(0, 1)) begin
            r.bx = 7'($urandom_range(0, LON_BINS - 1));
            r.by = 6'($urandom_range(0, LAT_BINS - 1));
         end
      end else if (p < 99) begin
         r = make_op(lgba_pkg::REQ_READ_RANGE, 0, 0);
      end else begin
         r = make_op(lgba_pkg::REQ_CLEAR, 0, 0);
      end
      return r;
   endfunction

   initial begin
      foreach (grid_sum[i]) begin
         grid_sum[i] = 0;
         grid_cnt[i] = 0;
      end
      run_min = 8388607; run_max = 0;
      win_start = 0; win_len = 364708; step_reg = 5120;
      repeat (10) @(posedge clock);
      reset <= 0;
      // directed
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_RANGE, 0, 0));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_BIN, 0, 0));
      pending_reqs.push_back(make_add(0, 0, -23040, -8388608));
      pending_reqs.push_back(make_add(364708, 92160, 23040, 8388607));
      pending_reqs.push_back(make_add(364709, 100, 0, 5));
      pending_reqs.push_back(make_add(1000, 131071, 0, 5));
      pending_reqs.push_back(make_add(1000, 0, -32768, 5));
      pending_reqs.push_back(make_add(1000, 0, 32767, 5));
      pending_reqs.push_back(make_add(1000, 640, 320, -7));
      pending_reqs.push_back(make_add(1000, 0, -23040, 3));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_BIN, 0, 0));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_BIN, 72, 36));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_BIN, 73, 0));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_BIN, 0, 37));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_BIN, 127, 63));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_RANGE, 0, 0));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_CLEAR, 0, 0));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_BIN, 0, 0));
      pending_reqs.push_back(make_op(lgba_pkg::REQ_READ_RANGE, 0, 0));
      drain_grid();
      // register settings, extremes included
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_write(lgba_pkg::CSR_CONTOUR_STEP, 0);
               csr_write(lgba_pkg::CSR_WINDOW_START, 38'h3FFFFFFFFF - 16777215);
               csr_write(lgba_pkg::CSR_WINDOW_LENGTH, 16777215);
            end
            1: begin
               csr_write(lgba_pkg::CSR_CONTOUR_STEP, 65535);
               csr_write(lgba_pkg::CSR_WINDOW_START, 38'h3FFFFFFFFF);
               csr_write(lgba_pkg::CSR_WINDOW_LENGTH, 0);
            end
            2: begin
               csr_write(lgba_pkg::CSR_CONTOUR_STEP, 1);
               csr_write(lgba_pkg::CSR_WINDOW_START, 0);
               csr_write(lgba_pkg::CSR_WINDOW_LENGTH, 0);
            end
            default: begin
               csr_write(lgba_pkg::CSR_CONTOUR_STEP, $urandom_range(1, 65535));
               csr_write(lgba_pkg::CSR_WINDOW_START,
                         {$urandom, $urandom} >> $urandom_range(0, 37));
               csr_write(lgba_pkg::CSR_WINDOW_LENGTH, $urandom & 24'hFFFFFF);
            end
         endcase
         begin
            int hx, hy;
            hx = $urandom_range(0, LON_BINS - 1);
            hy = $urandom_range(0, LAT_BINS - 1);
            for (int k = 0; k < 172; k++) begin
               if (k % 40 == 0) begin
                  hx = $urandom_range(0, LON_BINS - 1);
                  hy = $urandom_range(0, LAT_BINS - 1);
               end
               pending_reqs.push_back(rand_req(hx, hy));
            end
         end
         drain_grid();
      end
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
